// File: design/xml_name_escape_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// XML name escape encoder: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef XML_NAME_ESCAPE_ENCODER_CORE_ASSERT_SVH
`define XML_NAME_ESCAPE_ENCODER_CORE_ASSERT_SVH

// condition must never hold at a clock edge
`define XNE_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// antecedent at one edge requires consequent at the next edge
`define XNE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/xne_pkg.sv
// ----------------------------------------------------------------------------
// XML name escape encoder package
// Payload types, byte classes, character constants and classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package xne_pkg;

   localparam logic [7:0] CHAR_Z          = 8'h5A;
   localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_X    = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X    = 8'h78;
   localparam logic [7:0] CHAR_UPPER_M    = 8'h4D;
   localparam logic [7:0] CHAR_LOWER_M    = 8'h6D;
   localparam logic [7:0] CHAR_UPPER_L    = 8'h4C;
   localparam logic [7:0] CHAR_LOWER_L    = 8'h6C;

   typedef enum logic [1:0] {
      CLS_ALNUM  = 2'd0,
      CLS_SPACE  = 2'd1,
      CLS_HYPHEN = 2'd2,
      CLS_OTHER  = 2'd3
   } cls_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       name_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       name_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] value;
      cls_type    cls;
   } job_byte_type;

   // one unit of back-end work: optional prefix then one to three bytes
   typedef struct packed {
      logic                     prefix;
      logic                     name_last;
      logic [1:0]               count;
      job_byte_type [2:0]       bytes;
   } job_type;

   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
             ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z));
   endfunction

   function automatic cls_type classify(input logic [7:0] b);
      cls_type c;
      if (b == CHAR_SPACE) begin
         c = CLS_SPACE;
      end else if (b == CHAR_HYPHEN) begin
         c = CLS_HYPHEN;
      end else if (is_letter(b) || ((b >= CHAR_ZERO) && (b <= CHAR_NINE))) begin
         c = CLS_ALNUM;
      end else begin
         c = CLS_OTHER;
      end
      return c;
   endfunction

   function automatic job_byte_type make_job_byte(input logic [7:0] b);
      job_byte_type j;
      j.value = b;
      j.cls   = classify(b);
      return j;
   endfunction

endpackage

`default_nettype wire

// File: design/xne_front.sv
// ----------------------------------------------------------------------------
// XML name escape encoder: front end
// Accepts input bytes, holds the head of each name and issues classified jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module xne_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   input  wire xne_pkg::req_type req_data,
   input  wire logic            q_full,
   output logic                 job_push,
   output xne_pkg::job_type     job_data
);

   logic [7:0] head0_ff, head0_in;
   logic [7:0] head1_ff, head1_in;
   logic [1:0] head_count_ff, head_count_in;
   logic       head_done_ff, head_done_in;

   logic       accept;
   logic       flush;
   logic [7:0] b0, b1;
   logic       xml;

   always_comb begin
      accept = req_push & ~q_full;
      flush  = (head_count_ff == 2'd2) | req_data.name_last;

      b0 = (head_count_ff == 2'd0) ? req_data.in_byte : head0_ff;
      b1 = (head_count_ff == 2'd1) ? req_data.in_byte : head1_ff;

      xml = (head_count_ff == 2'd2) &&
            ((head0_ff == xne_pkg::CHAR_LOWER_X) || (head0_ff == xne_pkg::CHAR_UPPER_X)) &&
            ((head1_ff == xne_pkg::CHAR_LOWER_M) || (head1_ff == xne_pkg::CHAR_UPPER_M)) &&
            ((req_data.in_byte == xne_pkg::CHAR_LOWER_L) ||
             (req_data.in_byte == xne_pkg::CHAR_UPPER_L));

      job_data.name_last = req_data.name_last;
      job_data.bytes[2]  = xne_pkg::make_job_byte(req_data.in_byte);
      if (head_done_ff) begin
         job_data.prefix   = 1'b0;
         job_data.count    = 2'd1;
         job_data.bytes[0] = xne_pkg::make_job_byte(req_data.in_byte);
         job_data.bytes[1] = xne_pkg::make_job_byte(req_data.in_byte);
      end else begin
         job_data.prefix   = xml | ~xne_pkg::is_letter(b0);
         job_data.count    = head_count_ff + 2'd1;
         job_data.bytes[0] = xne_pkg::make_job_byte(b0);
         job_data.bytes[1] = xne_pkg::make_job_byte(b1);
      end

      job_push = accept & (head_done_ff | flush);

      head0_in      = head0_ff;
      head1_in      = head1_ff;
      head_count_in = head_count_ff;
      head_done_in  = head_done_ff;
      if (accept) begin
         if (req_data.name_last) begin
            head_count_in = 2'd0;
            head_done_in  = 1'b0;
         end else if (!head_done_ff && flush) begin
            head_count_in = 2'd0;
            head_done_in  = 1'b1;
         end else if (!head_done_ff) begin
            // hold the byte until the head is complete
            if (head_count_ff == 2'd0) begin
               head0_in = req_data.in_byte;
            end else begin
               head1_in = req_data.in_byte;
            end
            head_count_in = head_count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head0_ff <= head0_in;
      head1_ff <= head1_in;
      if (reset) begin
         head_count_ff <= 2'd0;
         head_done_ff  <= 1'b0;
      end else begin
         head_count_ff <= head_count_in;
         head_done_ff  <= head_done_in;
      end
   end

endmodule

`default_nettype wire

// File: design/xne_job_queue.sv
// ----------------------------------------------------------------------------
// XML name escape encoder: job queue
// Two-entry queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module xne_job_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire xne_pkg::job_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output xne_pkg::job_type      pop_data
);

   xne_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      full     = (count_ff == 2'd2);
      valid    = (count_ff != 2'd0);
      pop_data = mem_ff[rd_ptr_ff];
      do_push  = push & ~full;
      do_pop   = pop & valid;
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/xne_back.sv
// ----------------------------------------------------------------------------
// XML name escape encoder: back end
// Expands a job into encoded result bytes, one per cycle unless output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module xne_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire xne_pkg::job_type job_data,
   output logic                  job_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output xne_pkg::rsp_type      rsp_data
);

   xne_pkg::job_type     cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [1:0]           pfx_ff, pfx_in;
   logic [1:0]           idx_ff, idx_in;
   logic [1:0]           sub_ff, sub_in;
   xne_pkg::rsp_type     out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   xne_pkg::job_byte_type cur_byte;
   logic                  in_prefix;
   logic                  enc_last;
   logic                  run_last;
   logic                  emit;
   logic                  load;
   logic [7:0]            ch;

   always_comb begin
      cur_byte  = cur_ff.bytes[idx_ff];
      in_prefix = cur_ff.prefix & (pfx_ff != 2'd3);

      enc_last = 1'b1;
      ch       = cur_byte.value;
      case (cur_byte.cls)
         xne_pkg::CLS_ALNUM: begin
            ch = cur_byte.value;
         end
         xne_pkg::CLS_SPACE: begin
            ch = xne_pkg::CHAR_UNDERSCORE;
         end
         xne_pkg::CLS_HYPHEN: begin
            ch       = xne_pkg::CHAR_HYPHEN;
            enc_last = (sub_ff == 2'd1);
         end
         xne_pkg::CLS_OTHER: begin
            enc_last = (sub_ff == 2'd3);
            case (sub_ff)
               2'd0:    ch = xne_pkg::CHAR_HYPHEN;
               2'd1:    ch = xne_pkg::CHAR_ZERO + {6'd0, cur_byte.value[7:6]};
               2'd2:    ch = xne_pkg::CHAR_ZERO + {5'd0, cur_byte.value[5:3]};
               default: ch = xne_pkg::CHAR_ZERO + {5'd0, cur_byte.value[2:0]};
            endcase
         end
         default: begin
            ch = cur_byte.value;
         end
      endcase

      if (in_prefix) begin
         case (pfx_ff)
            2'd0:    ch = xne_pkg::CHAR_Z;
            2'd1:    ch = xne_pkg::CHAR_HYPHEN;
            default: ch = xne_pkg::CHAR_UNDERSCORE;
         endcase
      end

      run_last = ~in_prefix & enc_last & (idx_ff == (cur_ff.count - 2'd1));

      emit    = cur_valid_ff & (~out_valid_ff | rsp_pop);
      load    = ~cur_valid_ff | (emit & run_last);
      job_pop = load & job_valid;

      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      if (emit) begin
         out_in.out_byte = ch;
         out_in.run_last = run_last;
         out_in.name_end = run_last & cur_ff.name_last;
         out_valid_in    = 1'b1;
      end

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pfx_in       = pfx_ff;
      idx_in       = idx_ff;
      sub_in       = sub_ff;
      if (load) begin
         // take the next job straight after the last byte of this one
         cur_in       = job_data;
         cur_valid_in = job_valid;
         pfx_in       = 2'd0;
         idx_in       = 2'd0;
         sub_in       = 2'd0;
      end else if (emit) begin
         if (in_prefix) begin
            pfx_in = pfx_ff + 2'd1;
         end else if (enc_last) begin
            idx_in = idx_ff + 2'd1;
            sub_in = 2'd0;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end

      rsp_empty = ~out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pfx_ff       <= 2'd0;
         idx_ff       <= 2'd0;
         sub_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         pfx_ff       <= pfx_in;
         idx_ff       <= idx_in;
         sub_ff       <= sub_in;
      end
   end

endmodule

`default_nettype wire

// File: design/xml_name_escape_encoder_core.sv
// ----------------------------------------------------------------------------
// XML name escape encoder core
// Encodes streamed names into XML-safe names, one byte a cycle unless stalled.
//
//   Channel   Ports                        Direction   Payload
//   request   req_push / req_full          in          xne_pkg::req_type
//   response  rsp_empty / rsp_pop          out         xne_pkg::rsp_type
//
// The back end emits one result byte per cycle unless the result register
// stalls; an input byte encodes to one to four result bytes (the prefix adds
// three for the head). A first result passes through the job queue, the back
// end's current-job register and the result register. A two-entry job queue
// lets the front end take transactions while the back end is busy or the
// result register stalls. Reset is synchronous and clears all control state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xml_name_escape_encoder_core_assert.svh"

module xml_name_escape_encoder_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire xne_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output xne_pkg::rsp_type      rsp_data
);

   logic             job_push;
   xne_pkg::job_type job_in;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;
   xne_pkg::job_type q_data;
   logic             rsp_bad_end;
   logic             job_no_bytes;

   assign req_full = q_full;

   assign rsp_bad_end  = ~rsp_empty & rsp_data.name_end & ~rsp_data.run_last;
   assign job_no_bytes = job_push & (job_in.count == 2'd0);

   xne_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .job_push (job_push),
      .job_data (job_in)
   );

   xne_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   xne_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_data  (q_data),
      .job_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   `XNE_ASSERT_NEVER(a_no_push_when_full, job_push && q_full, "job pushed into a full queue")
   `XNE_ASSERT_NEVER(a_name_end_closes_run, rsp_bad_end, "name end without run end")
   `XNE_ASSERT_NEVER(a_job_count_range, job_no_bytes, "job with no bytes")
   `XNE_ASSERT_NEXT(a_pop_needs_job, q_pop, !q_full, "queue still full after pop")

endmodule

`default_nettype wire
